// File: sv/jscm_pkg.sv
// ----------------------------------------------------------------------------
// jscm_pkg: shared types and constants of the job slot concurrency manager
// Holds command, result and state codes plus the control and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package jscm_pkg;

    // Table geometry.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Field widths.
    localparam int CMD_W   = 3;
    localparam int ID_W    = 22;
    localparam int STAMP_W = 32;
    localparam int LIM_W   = 7;
    localparam int SLOT_OW = 6;

    // Limit after reset.
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(3);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_RESUME   = 3'd2,
        CMD_KILL     = 3'd3,
        CMD_LIST     = 3'd4,
        CMD_REAPED   = 3'd5,
        CMD_KILL_ALL = 3'd6,
        CMD_NOP      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        CODE_OK        = 2'd0,
        CODE_NOT_FOUND = 2'd1,
        CODE_FULL      = 2'd2
    } code_t;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_STOPPED = 2'd1,
        ST_DEAD    = 2'd2
    } entry_state_t;

    typedef enum logic [1:0] {
        SIDE_NONE    = 2'd0,
        SIDE_RESUMED = 2'd1,
        SIDE_STOPPED = 2'd2
    } side_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_APPLY,
        S_SCAN2,
        S_DECIDE,
        S_ADD,
        S_KALL,
        S_LIST
    } fsm_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;
        logic scan1;
        logic apply;
        logic scan2;
        logic side;
        logic add;
        logic kall;
        logic list;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic scan_end;
        logic out_busy;
    } stat_t;

endpackage

// File: sv/jscm_ctrl.sv
// ----------------------------------------------------------------------------
// jscm_ctrl: command sequencer
// Steps each transaction through its scans and result loads.
// ----------------------------------------------------------------------------
module jscm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  jscm_pkg::cmd_t    in_cmd,
    input  jscm_pkg::stat_t   stat,
    output logic              in_ready,
    output jscm_pkg::ctrl_t   ctl
);

    jscm_pkg::fsm_t state_reg;
    jscm_pkg::fsm_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jscm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            jscm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cap = 1'b1;
                    case (in_cmd)
                        jscm_pkg::CMD_ADD:      state_next = jscm_pkg::S_SCAN2;
                        jscm_pkg::CMD_STOP,
                        jscm_pkg::CMD_RESUME,
                        jscm_pkg::CMD_KILL,
                        jscm_pkg::CMD_REAPED:   state_next = jscm_pkg::S_SCAN1;
                        jscm_pkg::CMD_LIST:     state_next = jscm_pkg::S_LIST;
                        jscm_pkg::CMD_KILL_ALL: state_next = jscm_pkg::S_KALL;
                        default:                state_next = jscm_pkg::S_IDLE;
                    endcase
                end
            end
            jscm_pkg::S_SCAN1:
            begin
                if (stat.scan_end)
                begin
                    state_next = jscm_pkg::S_APPLY;
                end
                else
                begin
                    ctl.scan1 = 1'b1;
                end
            end
            jscm_pkg::S_APPLY:
            begin
                ctl.apply  = 1'b1;
                state_next = jscm_pkg::S_SCAN2;
            end
            jscm_pkg::S_SCAN2:
            begin
                if (stat.scan_end)
                begin
                    state_next = (stat.cmd == jscm_pkg::CMD_ADD) ? jscm_pkg::S_ADD
                                                                  : jscm_pkg::S_DECIDE;
                end
                else
                begin
                    ctl.scan2 = 1'b1;
                end
            end
            jscm_pkg::S_DECIDE:
            begin
                if (!stat.out_busy)
                begin
                    ctl.side   = 1'b1;
                    state_next = jscm_pkg::S_IDLE;
                end
            end
            jscm_pkg::S_ADD:
            begin
                if (!stat.out_busy)
                begin
                    ctl.add    = 1'b1;
                    state_next = jscm_pkg::S_IDLE;
                end
            end
            jscm_pkg::S_KALL:
            begin
                if (!stat.out_busy)
                begin
                    ctl.kall   = 1'b1;
                    state_next = jscm_pkg::S_IDLE;
                end
            end
            jscm_pkg::S_LIST:
            begin
                if (stat.scan_end)
                begin
                    state_next = jscm_pkg::S_IDLE;
                end
                else if (!stat.out_busy)
                begin
                    ctl.list = 1'b1;
                end
            end
            default:
            begin
                state_next = jscm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/jscm_datapath.sv
// ----------------------------------------------------------------------------
// jscm_datapath: slot table, scan unit and result register
// Holds the job table and flags, walks one slot per cycle in its scans under
// command of the controller, and presents results through a valid/ready register.
// ----------------------------------------------------------------------------
module jscm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  jscm_pkg::ctrl_t                     ctl,
    output jscm_pkg::stat_t                     stat,
    input  logic [jscm_pkg::CMD_W-1:0]          cmd,
    input  logic [jscm_pkg::ID_W-1:0]           job_id,
    input  logic [jscm_pkg::STAMP_W-1:0]        now,
    input  logic                                cfg_we,
    input  logic [jscm_pkg::LIM_W-1:0]          cfg_wdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          code,
    output logic [jscm_pkg::ID_W-1:0]           entry_id,
    output logic [jscm_pkg::SLOT_OW-1:0]        slot,
    output logic [1:0]                          entry_state,
    output logic [jscm_pkg::STAMP_W-1:0]        stamp,
    output logic [1:0]                          side_action,
    output logic [jscm_pkg::ID_W-1:0]           side_id,
    output logic                                last
);

    localparam int SW = jscm_pkg::SLOT_W;
    localparam int CW = jscm_pkg::CNT_W;
    localparam int IW = jscm_pkg::ID_W;
    localparam int TW = jscm_pkg::STAMP_W;
    localparam int LW = jscm_pkg::LIM_W;

    // Table storage.
    logic [IW-1:0]             id_mem_reg    [jscm_pkg::SLOTS];
    logic [TW-1:0]             stamp_mem_reg [jscm_pkg::SLOTS];
    logic [jscm_pkg::SLOTS-1:0] run_reg, run_next;
    logic [jscm_pkg::SLOTS-1:0] stop_reg, stop_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [LW-1:0]             limit_reg, limit_next;

    // Captured transaction and scan state.
    jscm_pkg::cmd_t            cmd_reg, cmd_next;
    logic [IW-1:0]             jid_reg, jid_next;
    logic [TW-1:0]             now_reg, now_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic                      found_reg, found_next;
    logic [SW-1:0]             f_reg, f_next;
    logic [CW-1:0]             nrun_reg, nrun_next;
    logic                      bv_reg, bv_next;
    logic [SW-1:0]             best_reg, best_next;
    logic [TW-1:0]             bstamp_reg, bstamp_next;
    logic [IW-1:0]             bid_reg, bid_next;

    // Result register.
    logic                      ov_reg, ov_next;
    logic [1:0]                code_reg, code_next;
    logic [IW-1:0]             eid_reg, eid_next;
    logic [jscm_pkg::SLOT_OW-1:0] slot_reg, slot_next;
    logic [1:0]                est_reg, est_next;
    logic [TW-1:0]             stamp_reg, stamp_next;
    logic [1:0]                act_reg, act_next;
    logic [IW-1:0]             sid_reg, sid_next;
    logic                      last_reg, last_next;

    // Table write port.
    logic                      st_we, id_we;
    logic [SW-1:0]             wr_addr;

    logic [SW-1:0]             cur;
    logic [IW-1:0]             cur_id;
    logic [TW-1:0]             cur_stamp;
    logic                      tgt;
    logic                      side_ok;
    logic                      add_run;

    assign cur       = idx_reg[SW-1:0];
    assign cur_id    = id_mem_reg[cur];
    assign cur_stamp = stamp_mem_reg[cur];

    assign stat.cmd      = cmd_reg;
    assign stat.scan_end = (idx_reg == count_reg);
    assign stat.out_busy = ov_reg;

    // Next-state logic of the datapath.
    always_comb
    begin
        run_next    = run_reg;
        stop_next   = stop_reg;
        count_next  = count_reg;
        limit_next  = cfg_we ? cfg_wdata : limit_reg;
        cmd_next    = cmd_reg;
        jid_next    = jid_reg;
        now_next    = now_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        f_next      = f_reg;
        nrun_next   = nrun_reg;
        bv_next     = bv_reg;
        best_next   = best_reg;
        bstamp_next = bstamp_reg;
        bid_next    = bid_reg;
        ov_next     = ov_reg && !out_ready;
        code_next   = code_reg;
        eid_next    = eid_reg;
        slot_next   = slot_reg;
        est_next    = est_reg;
        stamp_next  = stamp_reg;
        act_next    = act_reg;
        sid_next    = sid_reg;
        last_next   = last_reg;
        st_we       = 1'b0;
        id_we       = 1'b0;
        wr_addr     = f_reg;
        tgt         = (cmd_reg == jscm_pkg::CMD_RESUME) ? run_reg[cur] : stop_reg[cur];
        add_run     = ({{(LW-CW){1'b0}}, nrun_reg} < limit_reg);
        if (cmd_reg == jscm_pkg::CMD_RESUME)
        begin
            side_ok = (count_reg != '0) && ({{(LW-CW){1'b0}}, nrun_reg} > limit_reg)
                      && bv_reg && (bid_reg != jid_reg);
        end
        else
        begin
            side_ok = (count_reg != '0) && ({{(LW-CW){1'b0}}, nrun_reg} < limit_reg)
                      && bv_reg && (bid_reg != jid_reg);
        end

        // Capture a new transaction and clear the scan state.
        if (ctl.cap)
        begin
            cmd_next   = jscm_pkg::cmd_t'(cmd);
            jid_next   = job_id;
            now_next   = now;
            idx_next   = '0;
            found_next = 1'b0;
            f_next     = '0;
            nrun_next  = '0;
            bv_next    = 1'b0;
        end

        // First scan: locate the first live entry with the named id.
        if (ctl.scan1)
        begin
            idx_next = idx_reg + CW'(1);
            if (!found_reg && (run_reg[cur] || stop_reg[cur]) && (cur_id == jid_reg))
            begin
                found_next = 1'b1;
                f_next     = cur;
            end
        end

        // Change the named entry.
        if (ctl.apply)
        begin
            idx_next = '0;
            if (found_reg)
            begin
                run_next[f_reg]  = (cmd_reg == jscm_pkg::CMD_RESUME);
                stop_next[f_reg] = (cmd_reg == jscm_pkg::CMD_STOP);
                st_we            = 1'b1;
                wr_addr          = f_reg;
            end
        end

        // Second scan: count running jobs and find the earliest candidate.
        if (ctl.scan2)
        begin
            idx_next = idx_reg + CW'(1);
            if (run_reg[cur])
            begin
                nrun_next = nrun_reg + CW'(1);
            end
            if (tgt && (!bv_reg || (cur_stamp < bstamp_reg)))
            begin
                bv_next     = 1'b1;
                best_next   = cur;
                bstamp_next = cur_stamp;
                bid_next    = cur_id;
            end
        end

        // Side action and the result of stop, resume, kill and reaped.
        if (ctl.side)
        begin
            ov_next   = 1'b1;
            last_next = 1'b1;
            act_next  = jscm_pkg::SIDE_NONE;
            sid_next  = '0;
            if (side_ok)
            begin
                st_we    = 1'b1;
                wr_addr  = best_reg;
                sid_next = bid_reg;
                if (cmd_reg == jscm_pkg::CMD_RESUME)
                begin
                    run_next[best_reg]  = 1'b0;
                    stop_next[best_reg] = 1'b1;
                    act_next            = jscm_pkg::SIDE_STOPPED;
                end
                else
                begin
                    run_next[best_reg]  = 1'b1;
                    stop_next[best_reg] = 1'b0;
                    act_next            = jscm_pkg::SIDE_RESUMED;
                end
            end
            eid_next = jid_reg;
            if (found_reg)
            begin
                code_next  = jscm_pkg::CODE_OK;
                slot_next  = jscm_pkg::SLOT_OW'(f_reg);
                stamp_next = now_reg;
                case (cmd_reg)
                    jscm_pkg::CMD_RESUME: est_next = jscm_pkg::ST_RUNNING;
                    jscm_pkg::CMD_STOP:   est_next = jscm_pkg::ST_STOPPED;
                    default:              est_next = jscm_pkg::ST_DEAD;
                endcase
            end
            else
            begin
                code_next  = jscm_pkg::CODE_NOT_FOUND;
                slot_next  = '0;
                stamp_next = '0;
                est_next   = jscm_pkg::ST_RUNNING;
            end
        end

        // Append a job, or reject it when the table is full.
        if (ctl.add)
        begin
            ov_next   = 1'b1;
            last_next = 1'b1;
            act_next  = jscm_pkg::SIDE_NONE;
            sid_next  = '0;
            eid_next  = jid_reg;
            if (count_reg >= CW'(jscm_pkg::SLOTS))
            begin
                code_next  = jscm_pkg::CODE_FULL;
                slot_next  = '0;
                est_next   = jscm_pkg::ST_RUNNING;
                stamp_next = '0;
            end
            else
            begin
                wr_addr    = count_reg[SW-1:0];
                st_we      = 1'b1;
                id_we      = 1'b1;
                run_next[count_reg[SW-1:0]]  = add_run;
                stop_next[count_reg[SW-1:0]] = !add_run;
                count_next = count_reg + CW'(1);
                code_next  = jscm_pkg::CODE_OK;
                slot_next  = jscm_pkg::SLOT_OW'(count_reg[SW-1:0]);
                est_next   = add_run ? jscm_pkg::ST_RUNNING : jscm_pkg::ST_STOPPED;
                stamp_next = now_reg;
            end
        end

        // Mark every entry dead.
        if (ctl.kall)
        begin
            run_next   = '0;
            stop_next  = '0;
            ov_next    = 1'b1;
            last_next  = 1'b1;
            code_next  = jscm_pkg::CODE_OK;
            eid_next   = '0;
            slot_next  = '0;
            est_next   = jscm_pkg::ST_RUNNING;
            stamp_next = '0;
            act_next   = jscm_pkg::SIDE_NONE;
            sid_next   = '0;
        end

        // Report one occupied slot.
        if (ctl.list)
        begin
            idx_next   = idx_reg + CW'(1);
            ov_next    = 1'b1;
            last_next  = (idx_reg + CW'(1) == count_reg);
            code_next  = jscm_pkg::CODE_OK;
            eid_next   = cur_id;
            slot_next  = jscm_pkg::SLOT_OW'(cur);
            stamp_next = cur_stamp;
            act_next   = jscm_pkg::SIDE_NONE;
            sid_next   = '0;
            if (run_reg[cur])
            begin
                est_next = jscm_pkg::ST_RUNNING;
            end
            else if (stop_reg[cur])
            begin
                est_next = jscm_pkg::ST_STOPPED;
            end
            else
            begin
                est_next = jscm_pkg::ST_DEAD;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            stop_reg  <= '0;
            count_reg <= '0;
            limit_reg <= jscm_pkg::LIMIT_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            stop_reg  <= stop_next;
            count_reg <= count_next;
            limit_reg <= limit_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        jid_reg    <= jid_next;
        now_reg    <= now_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        f_reg      <= f_next;
        nrun_reg   <= nrun_next;
        bv_reg     <= bv_next;
        best_reg   <= best_next;
        bstamp_reg <= bstamp_next;
        bid_reg    <= bid_next;
        code_reg   <= code_next;
        eid_reg    <= eid_next;
        slot_reg   <= slot_next;
        est_reg    <= est_next;
        stamp_reg  <= stamp_next;
        act_reg    <= act_next;
        sid_reg    <= sid_next;
        last_reg   <= last_next;
        if (st_we)
        begin
            stamp_mem_reg[wr_addr] <= now_reg;
        end
        if (id_we)
        begin
            id_mem_reg[wr_addr] <= jid_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign code        = code_reg;
    assign entry_id    = eid_reg;
    assign slot        = slot_reg;
    assign entry_state = est_reg;
    assign stamp       = stamp_reg;
    assign side_action = act_reg;
    assign side_id     = sid_reg;
    assign last        = last_reg;

endmodule

// File: sv/job_slot_concurrency_manager_top.sv
// ----------------------------------------------------------------------------
// job_slot_concurrency_manager_top: job slot table with a running-job cap
// Top level joining the command sequencer and the table datapath.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; the table is walked one slot per
// cycle in the scans, while list waits for each result to be taken before
// it loads the next. Stop, resume, kill and reaped use two scans (one to
// find the job, one to count running jobs and pick the earliest candidate),
// add uses the second scan only and kill_all none. A result that is still
// waiting in the output register holds back the load of the next one. A new
// transaction is taken as soon as the result has been loaded into the output
// register, which holds it until it is taken.
module job_slot_concurrency_manager_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [jscm_pkg::CMD_W-1:0]          cmd,
    input  logic [jscm_pkg::ID_W-1:0]           job_id,
    input  logic [jscm_pkg::STAMP_W-1:0]        now,
    input  logic                                cfg_we,
    input  logic [jscm_pkg::LIM_W-1:0]          cfg_wdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          code,
    output logic [jscm_pkg::ID_W-1:0]           entry_id,
    output logic [jscm_pkg::SLOT_OW-1:0]        slot,
    output logic [1:0]                          entry_state,
    output logic [jscm_pkg::STAMP_W-1:0]        stamp,
    output logic [1:0]                          side_action,
    output logic [jscm_pkg::ID_W-1:0]           side_id,
    output logic                                last
);

    jscm_pkg::ctrl_t ctl;
    jscm_pkg::stat_t stat;

    // Sequencer.
    jscm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (jscm_pkg::cmd_t'(cmd)),
        .stat     (stat),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    // Table and result datapath.
    jscm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .job_id      (job_id),
        .now         (now),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code        (code),
        .entry_id    (entry_id),
        .slot        (slot),
        .entry_state (entry_state),
        .stamp       (stamp),
        .side_action (side_action),
        .side_id     (side_id),
        .last        (last)
    );

endmodule

// File: sv/jscm_checker.sv
// ----------------------------------------------------------------------------
// jscm_checker: port-level checks of the job slot concurrency manager
// Watches result transactions for hold behavior and field consistency.
// ----------------------------------------------------------------------------
module jscm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [1:0]                          code,
    input  logic [jscm_pkg::SLOT_OW-1:0]        slot,
    input  logic [1:0]                          entry_state,
    input  logic [jscm_pkg::STAMP_W-1:0]        stamp,
    input  logic [1:0]                          side_action,
    input  logic [jscm_pkg::ID_W-1:0]           side_id,
    input  logic                                last
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code) && $stable(stamp)
        && $stable(last))
        else $error("result changed while stalled");

    // A full-table reject is a single, bare result.
    a_full_bare: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && code == jscm_pkg::CODE_FULL |->
        last && side_action == jscm_pkg::SIDE_NONE && slot == '0 && stamp == '0)
        else $error("table-full result carries entry data");

    // A missing job reports no entry fields.
    a_nf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && code == jscm_pkg::CODE_NOT_FOUND |->
        last && slot == '0 && stamp == '0 && entry_state == jscm_pkg::ST_RUNNING)
        else $error("not-found result carries entry data");

    // No side action means no side id.
    a_side_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && side_action == jscm_pkg::SIDE_NONE |-> side_id == '0)
        else $error("side id without side action");

endmodule

bind job_slot_concurrency_manager_top jscm_checker u_jscm_checker (.*);

// File: test/job_slot_concurrency_manager_top_tb.sv
// ----------------------------------------------------------------------------
// job_slot_concurrency_manager_top_tb: self-checking bench of the job table
// Drives add, stop, resume, kill, list, reaped and kill_all transactions,
// predicts every result from a local model of the slot table and compares
// each result field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module job_slot_concurrency_manager_top_tb;

    import jscm_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    job_id;
        logic [STAMP_W-1:0] now;
    } job_cmd_t;

    typedef struct packed {
        logic [1:0]         code;
        logic [ID_W-1:0]    entry_id;
        logic [SLOT_OW-1:0] slot;
        logic [1:0]         entry_state;
        logic [STAMP_W-1:0] stamp;
        logic [1:0]         side_action;
        logic [ID_W-1:0]    side_id;
        logic               last;
    } job_result_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd;
    logic [ID_W-1:0]      job_id;
    logic [STAMP_W-1:0]   now;
    logic                 cfg_we;
    logic [LIM_W-1:0]     cfg_wdata;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           code;
    logic [ID_W-1:0]      entry_id;
    logic [SLOT_OW-1:0]   slot;
    logic [1:0]           entry_state;
    logic [STAMP_W-1:0]   stamp;
    logic [1:0]           side_action;
    logic [ID_W-1:0]      side_id;
    logic                 last;

    // Model of the slot table.
    logic [ID_W-1:0]      mdl_id [SLOTS];
    logic [STAMP_W-1:0]   mdl_stamp [SLOTS];
    logic                 mdl_run [SLOTS];
    logic                 mdl_stop [SLOTS];
    int                   mdl_count;
    int                   mdl_limit;

    job_cmd_t             pending_cmds [$];
    job_result_t          expected_results [$];
    int                   error_count;
    int                   results_seen;
    int                   accepted_cmds;
    int                   idle_cycles;
    bit                   stim_done;
    int                   burst_left;
    int                   gap_left;
    int                   hold_off;
    bit                   hold_req;
    logic [ID_W-1:0]      id_pool [8];

    job_slot_concurrency_manager_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .job_id      (job_id),
        .now         (now),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code        (code),
        .entry_id    (entry_id),
        .slot        (slot),
        .entry_state (entry_state),
        .stamp       (stamp),
        .side_action (side_action),
        .side_id     (side_id),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int running_jobs();
        int n;
        n = 0;
        for (int i = 0; i < mdl_count; i++)
            if (mdl_run[i]) n++;
        return n;
    endfunction

    // Earliest flagged entry; lowest slot wins a tie.
    function automatic int earliest_job(input bit want_running);
        int best;
        best = -1;
        for (int i = 0; i < mdl_count; i++)
        begin
            if (want_running ? !mdl_run[i] : !mdl_stop[i])
                continue;
            if (best < 0 || mdl_stamp[i] < mdl_stamp[best])
                best = i;
        end
        return best;
    endfunction

    function automatic job_result_t entry_report(input int s);
        job_result_t r;
        r = '0;
        r.code        = CODE_OK;
        r.entry_id    = mdl_id[s];
        r.slot        = SLOT_OW'(s);
        r.entry_state = mdl_run[s] ? ST_RUNNING : (mdl_stop[s] ? ST_STOPPED : ST_DEAD);
        r.stamp       = mdl_stamp[s];
        return r;
    endfunction

    // Apply one command to the table model and queue its results.
    task automatic predict_job_cmd(input job_cmd_t c);
        job_result_t r;
        int f;
        int e;
        logic [1:0] act;
        logic [ID_W-1:0] sid;
        r = '0;
        f = -1;
        act = SIDE_NONE;
        sid = '0;
        case (c.cmd)
            CMD_NOP:
            begin
            end
            CMD_LIST:
            begin
                for (int i = 0; i < mdl_count; i++)
                begin
                    r = entry_report(i);
                    r.last = (i == mdl_count - 1);
                    expected_results.push_back(r);
                end
            end
            CMD_KILL_ALL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    mdl_run[i] = 1'b0;
                    mdl_stop[i] = 1'b0;
                end
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            CMD_ADD:
            begin
                if (mdl_count >= SLOTS)
                begin
                    r.code = CODE_FULL;
                    r.entry_id = c.job_id;
                end
                else
                begin
                    mdl_id[mdl_count] = c.job_id;
                    mdl_stamp[mdl_count] = c.now;
                    mdl_run[mdl_count] = running_jobs() < mdl_limit;
                    mdl_stop[mdl_count] = !mdl_run[mdl_count];
                    r = entry_report(mdl_count);
                    mdl_count++;
                end
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            default:
            begin
                for (int i = 0; i < mdl_count; i++)
                    if ((mdl_run[i] || mdl_stop[i]) && mdl_id[i] == c.job_id)
                    begin
                        f = i;
                        break;
                    end
                if (f >= 0)
                begin
                    mdl_run[f] = (c.cmd == CMD_RESUME);
                    mdl_stop[f] = (c.cmd == CMD_STOP);
                    mdl_stamp[f] = c.now;
                end
                if (c.cmd == CMD_RESUME)
                begin
                    if (mdl_count > 0 && running_jobs() > mdl_limit)
                    begin
                        e = earliest_job(1'b1);
                        if (e >= 0 && mdl_id[e] != c.job_id)
                        begin
                            mdl_run[e] = 1'b0;
                            mdl_stop[e] = 1'b1;
                            mdl_stamp[e] = c.now;
                            act = SIDE_STOPPED;
                            sid = mdl_id[e];
                        end
                    end
                end
                else if (mdl_count > 0 && running_jobs() < mdl_limit)
                begin
                    e = earliest_job(1'b0);
                    if (e >= 0 && mdl_id[e] != c.job_id)
                    begin
                        mdl_run[e] = 1'b1;
                        mdl_stop[e] = 1'b0;
                        mdl_stamp[e] = c.now;
                        act = SIDE_RESUMED;
                        sid = mdl_id[e];
                    end
                end
                if (f >= 0)
                    r = entry_report(f);
                else
                begin
                    r.code = CODE_NOT_FOUND;
                    r.entry_id = c.job_id;
                end
                r.side_action = act;
                r.side_id = sid;
                r.last = 1'b1;
                expected_results.push_back(r);
            end
        endcase
    endtask

    function automatic job_cmd_t make_cmd(input cmd_t op, input logic [ID_W-1:0] id,
                                          input logic [STAMP_W-1:0] t);
        job_cmd_t c;
        c.cmd = op;
        c.job_id = id;
        c.now = t;
        return c;
    endfunction

    // Random command that mostly names ids from a small pool.
    function automatic job_cmd_t random_cmd();
        job_cmd_t c;
        int p;
        p = $urandom_range(99);
        if (p < 30)
            c.cmd = CMD_ADD;
        else if (p < 45)
            c.cmd = CMD_STOP;
        else if (p < 62)
            c.cmd = CMD_RESUME;
        else if (p < 72)
            c.cmd = CMD_KILL;
        else if (p < 80)
            c.cmd = CMD_REAPED;
        else if (p < 89)
            c.cmd = CMD_LIST;
        else if (p < 93)
            c.cmd = CMD_KILL_ALL;
        else
            c.cmd = CMD_NOP;
        if ($urandom_range(9) < 8)
            c.job_id = id_pool[$urandom_range(7)];
        else
            c.job_id = ID_W'($urandom);
        // Small stamp range makes ties common.
        if ($urandom_range(3) == 0)
            c.now = $urandom;
        else
            c.now = $urandom_range(7);
        return c;
    endfunction

    // Wait until every queued command is taken and every result checked.
    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        mdl_limit = v;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_ready)
            begin
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                {cmd, job_id, now} <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(12);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(40);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: own stall pattern, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && hold_off == 0)
            begin
                hold_off <= 1500;
                hold_req <= 1'b0;
                out_ready <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= (hold_off == 1);
            end
            else if ((accepted_cmds / 64) % 2 == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(3) != 0);
        end
    end

    // Monitor: predict on accepted commands, check accepted results.
    always @(posedge clk)
    begin
        job_result_t got;
        job_result_t want;
        if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready)
            begin
                predict_job_cmd(job_cmd_t'({cmd, job_id, now}));
                accepted_cmds <= accepted_cmds + 1;
                idle_cycles <= 0;
            end
            if (out_valid && out_ready)
            begin
                idle_cycles <= 0;
                results_seen <= results_seen + 1;
                got = {code, entry_id, slot, entry_state, stamp, side_action, side_id, last};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction.
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int limits [5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cmd = CMD_NOP;
        job_id = '0;
        now = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        results_seen = 0;
        accepted_cmds = 0;
        idle_cycles = 0;
        stim_done = 0;
        burst_left = 0;
        gap_left = 0;
        hold_off = 0;
        hold_req = 0;
        mdl_count = 0;
        mdl_limit = LIMIT_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            mdl_id[i] = '0;
            mdl_stamp[i] = '0;
            mdl_run[i] = 1'b0;
            mdl_stop[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            id_pool[i] = ID_W'($urandom);
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty list, misses, adds past the limit, table full, ties.
        pending_cmds.push_back(make_cmd(CMD_LIST, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_STOP, 5, 1));
        pending_cmds.push_back(make_cmd(CMD_ADD, '0, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(CMD_ADD, '1, 0));
        pending_cmds.push_back(make_cmd(CMD_ADD, 22'h2AAAAA, 0));
        pending_cmds.push_back(make_cmd(CMD_ADD, 22'h155555, 0));
        pending_cmds.push_back(make_cmd(CMD_ADD, 22'h155555, 32'hAAAA_AAAA));
        pending_cmds.push_back(make_cmd(CMD_RESUME, 22'h155555, 2));
        pending_cmds.push_back(make_cmd(CMD_STOP, '1, 3));
        pending_cmds.push_back(make_cmd(CMD_KILL, '0, 32'h5555_5555));
        pending_cmds.push_back(make_cmd(CMD_REAPED, 22'h2AAAAA, 4));
        pending_cmds.push_back(make_cmd(CMD_NOP, 7, 7));
        pending_cmds.push_back(make_cmd(CMD_KILL, '0, 9));
        pending_cmds.push_back(make_cmd(CMD_LIST, 0, 0));
        for (int i = 0; i < 12; i++)
            pending_cmds.push_back(make_cmd(CMD_ADD, ID_W'(i + 100), 0));
        pending_cmds.push_back(make_cmd(CMD_LIST, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_KILL_ALL, 0, 0));
        drain();

        // Random phases, each under its own limit; nothing frees a slot, not even
        // kill_all, so the table stays full and the full-table case recurs often.
        limits = '{1, 64, 0, 2, 127};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_limit(LIM_W'(limits[ph]));
            if (ph == 1)
                hold_req = 1'b1;
            for (int k = 0; k < 75; k++)
                pending_cmds.push_back(random_cmd());
            drain();
        end
        write_limit(LIM_W'(3));
        for (int k = 0; k < 10; k++)
            pending_cmds.push_back(random_cmd());
        drain();

        $display("Ran %0d commands, checked %0d results over limits 0, 1, 2, 3, 64 and 127.",
                 accepted_cmds, results_seen);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: job_slot_concurrency_manager_top.f
sv/jscm_pkg.sv
sv/jscm_ctrl.sv
sv/jscm_datapath.sv
sv/job_slot_concurrency_manager_top.sv
sv/jscm_checker.sv
test/job_slot_concurrency_manager_top_tb.sv
